FILE: hw/rtl/bit_plane_row_deserializer_unit_macros.svh
// assertion macros used by the top level of the bit-plane row deserializer rtl
`ifndef BIT_PLANE_ROW_DESERIALIZER_UNIT_MACROS_SVH
`define BIT_PLANE_ROW_DESERIALIZER_UNIT_MACROS_SVH

// checked only out of reset
`define BPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BPR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bpr_pkg.sv
// constants, types and helper functions for the bit-plane row deserializer
`default_nettype none

package bpr_pkg;

  localparam int ROW_PIXELS  = 256;
  localparam int BIT_PLANES  = 14;

  localparam int PLANE_BYTES = ROW_PIXELS / 8;
  localparam int GRP_W       = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
  localparam int PLANE_W     = $clog2(BIT_PLANES);
  localparam int ACC_W       = BIT_PLANES - 1;

  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 14;
  localparam int GIDX_W      = 5;
  localparam int PIX_EXT_W   = (BIT_PLANES > PIX_W) ? BIT_PLANES : PIX_W;
  localparam int GRP_EXT_W   = (GRP_W > GIDX_W) ? GRP_W : GIDX_W;

  // partial counts of one group of eight pixels, index 0 is the lowest column
  typedef logic [7:0][ACC_W-1:0] acc_t;
  typedef logic [7:0][PIX_W-1:0] pix_row_t;

  // full count cut or widened to the output width
  function automatic logic [PIX_W-1:0] pix_fit(input logic [BIT_PLANES-1:0] v);
    logic [PIX_EXT_W-1:0] t;
    t = PIX_EXT_W'(v);
    return t[PIX_W-1:0];
  endfunction

  // group number taken modulo 32
  function automatic logic [GIDX_W-1:0] grp_fit(input logic [GRP_W-1:0] g);
    logic [GRP_EXT_W-1:0] t;
    t = GRP_EXT_W'(g);
    return t[GIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bpr_cell.sv
// one cell of the rotating chain: partial counts of one pixel group
`default_nettype none

module bpr_cell (
  input  wire logic         clk,
  input  wire logic         shift_en,
  input  wire bpr_pkg::acc_t d_in,
  output      bpr_pkg::acc_t q
);

  bpr_pkg::acc_t acc_r;
  bpr_pkg::acc_t acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (shift_en) begin
      acc_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign q = acc_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bpr_merge.sv
// folds one plane byte into the partial counts leaving the head of the chain
`default_nettype none

module bpr_merge (
  input  wire logic [bpr_pkg::BYTE_W-1:0] byte_in,
  input  wire logic                       first_plane,
  input  wire bpr_pkg::acc_t              head_acc,
  output      bpr_pkg::acc_t              acc_out,
  output      bpr_pkg::pix_row_t          pix_out
);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      // msb of the byte belongs to the lowest column of the group
      if (first_plane) begin
        acc_out[i] = bpr_pkg::ACC_W'(byte_in[7-i]);
      end else begin
        acc_out[i] = (head_acc[i] << 1) | bpr_pkg::ACC_W'(byte_in[7-i]);
      end
      pix_out[i] = bpr_pkg::pix_fit({head_acc[i], byte_in[7-i]});
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bit_plane_row_deserializer_unit.sv
// top level of the bit-plane row deserializer
//
//  channel | ports                               | direction | transaction
//  --------+-------------------------------------+-----------+-------------------------
//  in      | in_valid in_ready in_stream_byte    | sink      | one byte of the row
//  out     | out_valid out_ready out_group_index | source    | eight pixel counts of
//          | out_pixel_* out_row_done            |           | one group
//
// one byte is taken per cycle while in_ready is high; a group result leaves in the cycle after its last-plane byte.
// the partial counts rotate through a chain of ROW_PIXELS/8 cells, one step per byte.
// reset clears the plane and group counters and the output valid; cell contents need none.
// a stalled result holds in the output register and input is taken only when it can move.
`default_nettype none
`include "bit_plane_row_deserializer_unit_macros.svh"

module bit_plane_row_deserializer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [bpr_pkg::BYTE_W-1:0]  in_stream_byte,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [bpr_pkg::GIDX_W-1:0]  out_group_index,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_zero,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_one,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_two,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_three,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_four,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_five,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_six,
  output      logic [bpr_pkg::PIX_W-1:0]   out_pixel_seven,
  output      logic                        out_row_done
);

  localparam int NCELL = bpr_pkg::PLANE_BYTES;

  logic [bpr_pkg::PLANE_W-1:0] plane_r, plane_nxt;
  logic [bpr_pkg::GRP_W-1:0]   grp_r, grp_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bpr_pkg::GIDX_W-1:0]  gidx_r, gidx_nxt;
  bpr_pkg::pix_row_t           pix_r, pix_nxt;
  logic                        done_r, done_nxt;

  logic in_fire;
  logic first_plane;
  logic last_plane;
  logic last_grp;

  bpr_pkg::acc_t       cell_q [NCELL];
  bpr_pkg::acc_t       merge_acc;
  bpr_pkg::pix_row_t   merge_pix;

  assign in_ready    = !out_valid_r || out_ready;
  assign in_fire     = in_valid && in_ready;
  assign first_plane = (plane_r == '0);
  assign last_plane  = (plane_r == bpr_pkg::PLANE_W'(bpr_pkg::BIT_PLANES - 1));
  assign last_grp    = (grp_r == bpr_pkg::GRP_W'(NCELL - 1));

  bpr_merge u_merge (
    .byte_in     (in_stream_byte),
    .first_plane (first_plane),
    .head_acc    (cell_q[0]),
    .acc_out     (merge_acc),
    .pix_out     (merge_pix)
  );

  // ring of cells: the head feeds the merge, the merged counts re-enter at the tail
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    bpr_pkg::acc_t d_w;
    if (c == NCELL - 1) begin : g_tail
      assign d_w = merge_acc;
    end else begin : g_mid
      assign d_w = cell_q[c+1];
    end
    bpr_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .d_in     (d_w),
      .q        (cell_q[c])
    );
  end

  always_comb begin
    plane_nxt = plane_r;
    grp_nxt   = grp_r;
    if (in_fire) begin
      if (last_grp) begin
        grp_nxt   = '0;
        plane_nxt = last_plane ? '0 : plane_r + 1'b1;
      end else begin
        grp_nxt = grp_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    gidx_nxt      = gidx_r;
    pix_nxt       = pix_r;
    done_nxt      = done_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && last_plane) begin
      out_valid_nxt = 1'b1;
      gidx_nxt      = bpr_pkg::grp_fit(grp_r);
      pix_nxt       = merge_pix;
      done_nxt      = last_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r     <= '0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      plane_r     <= plane_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gidx_r <= gidx_nxt;
    pix_r  <= pix_nxt;
    done_r <= done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_group_index = gidx_r;
  assign out_pixel_zero  = pix_r[0];
  assign out_pixel_one   = pix_r[1];
  assign out_pixel_two   = pix_r[2];
  assign out_pixel_three = pix_r[3];
  assign out_pixel_four  = pix_r[4];
  assign out_pixel_five  = pix_r[5];
  assign out_pixel_six   = pix_r[6];
  assign out_pixel_seven = pix_r[7];
  assign out_row_done    = done_r;

  `BPR_ASSERT(a_rise_from_last_plane, $rose(out_valid_r) |-> $past(in_fire && last_plane), "result raised without a last-plane byte")
  `BPR_ASSERT(a_plane_in_range, plane_r <= bpr_pkg::PLANE_W'(bpr_pkg::BIT_PLANES - 1), "plane counter out of range")
  `BPR_ASSERT(a_row_wrap, (in_fire && last_plane && last_grp) |=> (plane_r == '0 && grp_r == '0 && out_row_done), "row did not wrap after its final group")
  `BPR_ASSERT(a_no_fire_while_stalled, (out_valid_r && !out_ready) |-> !in_fire, "byte taken while a result is stalled")
  `BPR_ASSERT_RST(a_reset_clears, !rst_n |=> (!out_valid_r && plane_r == '0 && grp_r == '0), "reset did not clear control state")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// testbench for bit_plane_row_deserializer_unit: a directed row, random rows, predictor check
`timescale 1ns / 100ps

module tb;

  localparam int ROW_BYTES    = bpr_pkg::BIT_PLANES * bpr_pkg::PLANE_BYTES;
  localparam int STORED_BYTES = (bpr_pkg::BIT_PLANES - 1) * bpr_pkg::PLANE_BYTES;
  localparam int RANDOM_BYTES = 652;
  localparam int QUIET_BYTES  = 250;
  localparam int HANG_LIMIT   = 500;

  typedef struct packed {
    logic [bpr_pkg::GIDX_W-1:0] grp;
    bpr_pkg::pix_row_t          pix;
    logic                       last;
  } group_result_t;

  // one directed pattern: fill of the stored planes and of the last plane of a group
  typedef struct packed {
    logic [bpr_pkg::BYTE_W-1:0] plane_fill;
    logic [bpr_pkg::BYTE_W-1:0] last_fill;
    logic                       walk;
    logic                       typed;
    logic [bpr_pkg::PIX_W-1:0]  pix;
  } row_case_t;

  localparam row_case_t DIRECTED_ROWS [5] = '{
    '{8'h00, 8'h00, 1'b0, 1'b1, 14'h0000},  // all counts zero
    '{8'hFF, 8'hFF, 1'b0, 1'b1, 14'h3FFF},  // all counts full scale
    '{8'h00, 8'hFF, 1'b0, 1'b1, 14'h0001},  // only the lowest count bit
    '{8'hFF, 8'h00, 1'b0, 1'b1, 14'h3FFE},  // every bit but the lowest
    '{8'h80, 8'h01, 1'b1, 1'b0, 14'h0000}   // walking bit across planes and groups
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [bpr_pkg::BYTE_W-1:0]    in_stream_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [bpr_pkg::GIDX_W-1:0]    out_group_index;
  logic [bpr_pkg::PIX_W-1:0]     out_pixel_zero, out_pixel_one, out_pixel_two;
  logic [bpr_pkg::PIX_W-1:0]     out_pixel_three, out_pixel_four, out_pixel_five;
  logic [bpr_pkg::PIX_W-1:0]     out_pixel_six, out_pixel_seven;
  logic                          out_row_done;

  // predictor state
  logic [bpr_pkg::BYTE_W-1:0]    plane_bytes [STORED_BYTES];
  int unsigned                   row_pos = 0;

  group_result_t                 pending_groups [$];
  int unsigned                   errors = 0;
  int unsigned                   bytes_sent = 0;
  int unsigned                   groups_checked = 0;
  int unsigned                   stall_left = 0;
  int unsigned                   hang_cycles = 0;
  logic                          stall_en = 1'b0;
  bit                            gaps_on = 1'b0;
  bit                            typed_row = 1'b0;
  logic [bpr_pkg::PIX_W-1:0]     typed_pix = '0;

  bit_plane_row_deserializer_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_stream_byte  (in_stream_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_group_index (out_group_index),
    .out_pixel_zero  (out_pixel_zero),
    .out_pixel_one   (out_pixel_one),
    .out_pixel_two   (out_pixel_two),
    .out_pixel_three (out_pixel_three),
    .out_pixel_four  (out_pixel_four),
    .out_pixel_five  (out_pixel_five),
    .out_pixel_six   (out_pixel_six),
    .out_pixel_seven (out_pixel_seven),
    .out_row_done    (out_row_done)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < 40)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // stores a byte of the upper planes, or gathers one group from the last plane
  task automatic absorb_byte(input logic [bpr_pkg::BYTE_W-1:0] b, output bit has_group,
                             output group_result_t r);
    int unsigned g;
    int unsigned col;
    int unsigned p;
    int unsigned val;
    has_group = 1'b0;
    r = '0;
    if (row_pos >= ROW_BYTES) row_pos = 0;
    if (row_pos < STORED_BYTES) begin
      plane_bytes[row_pos] = b;
      row_pos++;
    end else begin
      g = row_pos - STORED_BYTES;
      r.grp = g[bpr_pkg::GIDX_W-1:0];
      for (col = 0; col < 8; col++) begin
        val = 0;
        // msb of a byte belongs to the lowest column of the group
        for (p = 0; p + 1 < bpr_pkg::BIT_PLANES; p++)
          if (plane_bytes[p * bpr_pkg::PLANE_BYTES + g][7 - col])
            val |= 1 << (bpr_pkg::BIT_PLANES - 1 - p);
        if (b[7 - col]) val |= 1;
        r.pix[col] = val[bpr_pkg::PIX_W-1:0];
      end
      r.last = (g + 1 == bpr_pkg::PLANE_BYTES);
      has_group = 1'b1;
      row_pos++;
      if (row_pos >= ROW_BYTES) row_pos = 0;
    end
  endtask

  task automatic send_byte(input logic [bpr_pkg::BYTE_W-1:0] b);
    bit            has_group;
    group_result_t r;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(b, has_group, r);
    if (has_group) begin
      if (typed_row)
        for (int i = 0; i < 8; i++) r.pix[i] = typed_pix;
      pending_groups.push_back(r);
    end
    bytes_sent++;
  endtask

  // sender holds off until every group result has come out
  task automatic drain_and_hold();
    in_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver stalls in bursts of random length while stall_en is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    group_result_t     want;
    bpr_pkg::pix_row_t got_pix;
    if (rst_n && out_valid && out_ready) begin
      got_pix = {out_pixel_seven, out_pixel_six, out_pixel_five, out_pixel_four,
                 out_pixel_three, out_pixel_two, out_pixel_one, out_pixel_zero};
      if (pending_groups.size() == 0) begin
        report_mismatch("unexpected group transaction, group", out_group_index, 0);
      end else begin
        want = pending_groups.pop_front();
        if (out_group_index !== want.grp)
          report_mismatch("group_index", out_group_index, want.grp);
        for (int i = 0; i < 8; i++)
          if (got_pix[i] !== want.pix[i])
            report_mismatch($sformatf("pixel %0d of group %0d", i, want.grp),
                            got_pix[i], want.pix[i]);
        if (out_row_done !== want.last)
          report_mismatch("row_done", out_row_done, want.last);
        groups_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      hang_cycles = 0;
    else
      hang_cycles++;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
      $display("FAIL bit_plane_row_deserializer_unit");
      $finish;
    end
  end

  initial begin
    int unsigned                k;
    int unsigned                pos;
    int unsigned                p;
    int unsigned                g;
    int unsigned                e;
    int unsigned                flavor;
    logic [bpr_pkg::BYTE_W-1:0] b;
    logic [bpr_pkg::BYTE_W-1:0] fill;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    stall_en <= 1'b1;
    @(posedge clk);

    // directed row: the table entries take turns across the groups of the row
    for (pos = 0; pos < ROW_BYTES; pos++) begin
      p = pos / bpr_pkg::PLANE_BYTES;
      g = pos % bpr_pkg::PLANE_BYTES;
      e = g % 5;
      typed_row = DIRECTED_ROWS[e].typed;
      typed_pix = DIRECTED_ROWS[e].pix;
      gaps_on = (e % 2 == 1);
      fill = (pos < STORED_BYTES) ? DIRECTED_ROWS[e].plane_fill
                                  : DIRECTED_ROWS[e].last_fill;
      if (DIRECTED_ROWS[e].walk)
        b = 8'(({fill, fill}) >> ((p + g) % 8));
      else
        b = fill;
      send_byte(b);
    end
    typed_row = 1'b0;
    drain_and_hold();

    // random rows of mixed density; the last stretch runs without gaps or stalls, apart from one drain
    flavor = 0;
    for (k = 0; k < RANDOM_BYTES; k++) begin
      pos = k % ROW_BYTES;
      if (pos == 0) flavor = $urandom_range(0, 3);
      if (k >= RANDOM_BYTES - QUIET_BYTES) begin
        gaps_on = 1'b0;
        stall_en <= 1'b0;
      end else if (k % 128 == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
        stall_en <= ($urandom_range(0, 2) != 0);
      end
      if (k == 600) drain_and_hold();
      case (flavor)
        1: b = ($urandom_range(0, 3) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
        2: b = ($urandom_range(0, 3) == 0) ? ~8'(1 << $urandom_range(0, 7)) : 8'hFF;
        3: b = (pos >= STORED_BYTES && $urandom_range(0, 1) == 0)
               ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
        default: b = 8'($urandom);
      endcase
      send_byte(b);
    end
    in_valid <= 1'b0;

    while (pending_groups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes: a directed row mixing zero, full scale, single plane groups",
             bytes_sent);
    $display("and walking bits, then random rows; %0d groups checked, %0d errors",
             groups_checked, errors);
    if (errors == 0)
      $display("PASS bit_plane_row_deserializer_unit");
    else
      $display("FAIL bit_plane_row_deserializer_unit");
    $finish;
  end

endmodule
